### hw/rtl/rcpc_pkg.sv
// Package for the RC pulse capture and scaling block.
// Holds widths, calibration reset values, register indexes and scaling constants.
// No dependencies.
`default_nettype none

package rcpc_pkg;

    // Fixed field widths.
    localparam int LANE_W   = 16;
    localparam int CFG_W    = 64;
    localparam int MAX_CH   = 4;
    localparam int CH_W     = 2;
    localparam int VALUE_W  = 11;
    localparam int TS_W     = 32;

    // Serial divider sizing: the quotient never exceeds HALF_SPAN, so nine bits do.
    localparam int QUO_W    = 9;
    localparam int STEP_W   = 4;
    localparam int REM_W    = LANE_W + QUO_W;

    localparam logic [QUO_W-1:0]   HALF_SPAN = 9'd500;
    localparam logic [VALUE_W-1:0] MID_VALUE = 11'd1500;
    localparam logic [VALUE_W-1:0] MIN_VALUE = 11'd1000;
    localparam logic [VALUE_W-1:0] MAX_VALUE = 11'd2000;

    // Calibration defaults, one 16-bit lane per channel.
    localparam logic [CFG_W-1:0] CENTER_RESET = 64'h05DC_05DC_05DC_05DC;
    localparam logic [CFG_W-1:0] LOW_RESET    = 64'h03E8_03E8_03E8_03E8;
    localparam logic [CFG_W-1:0] HIGH_RESET   = 64'h07D0_07D0_07D0_07D0;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_CENTER = 2'd0,
        REG_LOW    = 2'd1,
        REG_HIGH   = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_index;

endpackage

`default_nettype wire

### hw/rtl/rc_pulse_capture_and_scale.sv
// Top level of the RC pulse capture and scaling block.
// Depends on rcpc_pkg for widths, calibration defaults and register indexes.
//
// Usage:
// The input channel takes one word per pin sample: four pin levels and a
// microsecond timestamp. A rising pin stores the time, a falling pin ends a
// pulse. Each ended pulse gives one output word (channel, saturated width,
// scaled value 1000..2000, last flag), in ascending channel order; the last
// flag marks the final word caused by a sample.
// Each ended pulse passes through channel select, multiply, nine divider
// steps, final add and output load; the shared restoring divider produces
// one quotient bit a cycle. A pulse whose value needs no division (width at
// center, zero divisor or bound on the wrong side of center) goes from
// channel select straight to output load. A sample that ends no pulse
// leaves the block idle. The input is not ready while a sample is being
// worked on.
// Stalls: the last output word sits in the output register, and the next
// sample is taken while it waits. If the receiver stalls with an earlier
// word still held, the sequencer waits at the output load.
// Reset: all pins read as low, no pulse is open, the output register is
// empty and the calibration registers return to 1000/1500/2000 per channel.
// The user must write calibration through the plain write port only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module rc_pulse_capture_and_scale
    import rcpc_pkg::*;
#(
    parameter int CHANNELS  = 4,
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Sample input
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [MAX_CH-1:0]    i_pin_levels,
    input  wire logic [TS_W-1:0]      i_time_us,
    // Result output
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [CH_W-1:0]           o_channel,
    output logic [LANE_W-1:0]         o_pulse_width,
    output logic [VALUE_W-1:0]        o_scaled_value,
    output logic                      o_last,
    // Calibration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [MAX_CH-1:0] CH_MASK = MAX_CH'((1 << CHANNELS) - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_MUL,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [CFG_W-1:0]       r_center;
    logic [CFG_W-1:0]       r_low;
    logic [CFG_W-1:0]       r_high;
    logic [MAX_CH-1:0]      r_prev;
    logic [TIME_BITS-1:0]   r_rise [MAX_CH];
    logic [TIME_BITS-1:0]   r_now;
    logic [MAX_CH-1:0]      r_fall;
    logic [CH_W-1:0]        r_ch;
    logic [LANE_W-1:0]      r_width;
    logic                   r_last;
    logic [LANE_W-1:0]      r_num;
    logic [LANE_W-1:0]      r_den;
    logic                   r_neg;
    logic [REM_W-1:0]       r_rem;
    logic [QUO_W-1:0]       r_quo;
    logic [STEP_W-1:0]      r_step;
    logic [VALUE_W-1:0]     r_value;
    logic                   r_o_valid;
    logic [CH_W-1:0]        r_o_channel;
    logic [LANE_W-1:0]      r_o_width;
    logic [VALUE_W-1:0]     r_o_value;
    logic                   r_o_last;

    logic                   in_take;
    logic                   out_free;
    logic [MAX_CH-1:0]      pins;
    logic [TIME_BITS-1:0]   now;

    logic [CH_W-1:0]        n_ch;
    logic [TIME_BITS-1:0]   diff;
    logic [LANE_W-1:0]      n_width;
    logic [LANE_W-1:0]      lane_c;
    logic [LANE_W-1:0]      lane_l;
    logic [LANE_W-1:0]      lane_h;
    logic                   n_direct;
    logic [VALUE_W-1:0]     n_direct_value;
    logic [LANE_W-1:0]      n_num;
    logic [LANE_W-1:0]      n_den;
    logic                   n_neg;
    logic [MAX_CH-1:0]      n_fall;

    logic [REM_W-1:0]       div_shifted;
    logic                   div_fits;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_o_valid || i_out_ready;
    assign pins     = i_pin_levels & CH_MASK;
    assign now      = i_time_us[TIME_BITS-1:0];

    // Lowest channel with a pending falling edge.
    always_comb begin
        n_ch = '0;
        for (int i = MAX_CH - 1; i >= 0; i--) begin
            if (r_fall[i]) begin
                n_ch = CH_W'(i);
            end
        end
    end

    // Pulse width of the selected channel, wrapped and saturated to 16 bits.
    always_comb begin
        diff = r_now - r_rise[n_ch];
        if (TS_W'(diff) > TS_W'({LANE_W{1'b1}})) begin
            n_width = {LANE_W{1'b1}};
        end else begin
            n_width = LANE_W'(diff);
        end
    end

    // Calibration lanes and the choice between a fixed value and a division.
    // When the low or high bound lies on the wrong side of center, the value
    // is set directly to MIN_VALUE or MAX_VALUE, with no division.
    always_comb begin
        lane_c         = r_center[LANE_W*n_ch +: LANE_W];
        lane_l         = r_low[LANE_W*n_ch +: LANE_W];
        lane_h         = r_high[LANE_W*n_ch +: LANE_W];
        n_direct       = 1'b1;
        n_direct_value = MID_VALUE;
        n_num          = '0;
        n_den          = '0;
        n_neg          = 1'b0;
        if (n_width < lane_c) begin
            n_neg = 1'b1;
            if (lane_l > lane_c) begin
                n_direct_value = MIN_VALUE;
            end else if (lane_l != lane_c) begin
                n_direct = 1'b0;
                n_num    = lane_c - ((n_width < lane_l) ? lane_l : n_width);
                n_den    = lane_c - lane_l;
            end
        end else if (n_width > lane_c) begin
            if (lane_h < lane_c) begin
                n_direct_value = MAX_VALUE;
            end else if (lane_h != lane_c) begin
                n_direct = 1'b0;
                n_num    = ((n_width > lane_h) ? lane_h : n_width) - lane_c;
                n_den    = lane_h - lane_c;
            end
        end
        n_fall = r_fall & ~(MAX_CH'(1) << n_ch);
    end

    // Shared restoring divider step: one quotient bit per cycle.
    assign div_shifted = REM_W'(r_den) << r_step;
    assign div_fits    = (r_rem >= div_shifted);

    // Sequencer, state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_center  <= CENTER_RESET;
            r_low     <= LOW_RESET;
            r_high    <= HIGH_RESET;
            r_prev    <= '0;
            r_fall    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // Calibration writes; an index past the list is dropped.
            if (i_cfg_we) begin
                case (t_reg_index'(i_cfg_index))
                    REG_CENTER: r_center <= i_cfg_data;
                    REG_LOW:    r_low    <= i_cfg_data;
                    REG_HIGH:   r_high   <= i_cfg_data;
                    default:    ;
                endcase
            end

            // The held word leaves; the output load below refills it itself.
            if (r_o_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        for (int i = 0; i < MAX_CH; i++) begin
                            if (pins[i] && !r_prev[i]) begin
                                r_rise[i] <= now;
                            end
                        end
                        r_prev <= pins;
                        r_now  <= now;
                        r_fall <= r_prev & ~pins;
                        if ((r_prev & ~pins) != '0) begin
                            r_state <= S_SEL;
                        end
                    end
                end
                S_SEL: begin
                    r_ch    <= n_ch;
                    r_width <= n_width;
                    r_fall  <= n_fall;
                    r_last  <= (n_fall == '0);
                    r_num   <= n_num;
                    r_den   <= n_den;
                    r_neg   <= n_neg;
                    r_value <= n_direct_value;
                    r_state <= n_direct ? S_EMIT : S_MUL;
                end
                S_MUL: begin
                    r_rem   <= REM_W'(r_num) * REM_W'(HALF_SPAN);
                    r_quo   <= '0;
                    r_step  <= STEP_W'(QUO_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_fits) begin
                        r_rem         <= r_rem - div_shifted;
                        r_quo[r_step] <= 1'b1;
                    end
                    if (r_step == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                S_FIN: begin
                    if (r_neg) begin
                        r_value <= MID_VALUE - VALUE_W'(r_quo);
                    end else begin
                        r_value <= MID_VALUE + VALUE_W'(r_quo);
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_channel <= r_ch;
                        r_o_width   <= r_width;
                        r_o_value   <= r_value;
                        r_o_last    <= r_last;
                        r_state     <= r_last ? S_IDLE : S_SEL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_channel      = r_o_channel;
    assign o_pulse_width  = r_o_width;
    assign o_scaled_value = r_o_value;
    assign o_last         = r_o_last;

endmodule

`default_nettype wire
